// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared constants, coefficients and ROM builder
// Field widths, the Q0.16 coefficients of the three Taylor segments, and
// the elaboration-time builder of the sigmoid table used outside [-2,2).
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int X_WIDTH  = 12;
  localparam int Y_WIDTH  = 16;
  localparam int D0_W     = 16;
  localparam int D1_W     = 15;
  localparam int D2_W     = 13;
  localparam int ENT_W    = 17;
  localparam int ROM_SIZE = 2049;

  localparam logic [D0_W-1:0] D0_NEG = 16'd17623;
  localparam logic [D0_W-1:0] D0_MID = 16'd32768;
  localparam logic [D0_W-1:0] D0_POS = 16'd47913;

  localparam logic [D1_W-1:0] D1_OUTER = 15'd12884;
  localparam logic [D1_W-1:0] D1_MID   = 15'd16384;

  localparam logic signed [D2_W-1:0] D2_NEG = 13'sd2979;
  localparam logic signed [D2_W-1:0] D2_MID = 13'sd0;
  localparam logic signed [D2_W-1:0] D2_POS = -13'sd2979;

  localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;

  typedef logic [ROM_SIZE-1:0][ENT_W-1:0] rom_t;

  // Restoring division, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Truncated (a * b) >> 60 in Q60.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // round(65536 / (1 + E)) with E given in Q60.
  function automatic logic [ENT_W-1:0] sig_entry(input logic [63:0] e_q);
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] val;
    int          i;
    den = Q60_ONE + e_q;
    rem = e_q;
    quo = '0;
    for (i = 0; i < 36; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    val = 64'd65536 - ((quo + 64'd524288) >> 20);
    return val[ENT_W-1:0];
  endfunction

  // Table of round(65536 * sigmoid(k / 2^frac)) for k = 0 .. ROM_SIZE-1.
  function automatic rom_t build_rom(input int frac);
    rom_t        rom;
    logic [63:0] term;
    logic [63:0] step;
    logic [63:0] e;
    int          n;
    int          k;
    int          blk;
    int          j;
    term = Q60_ONE;
    step = Q60_ONE;
    e    = Q60_ONE;
    for (n = 1; n <= 20; n++) begin
      term = udiv64(term >> frac, 64'(n));
      if ((n & 1) != 0) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    for (blk = 0; blk <= (ROM_SIZE - 1) / 64; blk++) begin
      for (j = 0; j < 64; j++) begin
        k = blk * 64 + j;
        if (k < ROM_SIZE) begin
          rom[k] = sig_entry(e);
          e      = mul_q60(e, step);
        end
      end
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

// ===== design/spq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_front: segment decode and table read
// Picks the Taylor segment and its coefficients, forms the offset from the
// segment center, and reads the sigmoid table at the input magnitude.
// ----------------------------------------------------------------------------
module spq_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    x_valid,
  output logic                                    x_ready,
  input  logic signed [spq_pkg::X_WIDTH-1:0]      x,
  output logic                                    dec_valid,
  input  logic                                    dec_ready,
  output logic                                    dec_taylor,
  output logic                                    dec_neg,
  output logic signed [FRAC_BITS+1:0]             dec_d,
  output logic        [spq_pkg::D0_W-1:0]         dec_d0,
  output logic        [spq_pkg::D1_W-1:0]         dec_d1,
  output logic signed [spq_pkg::D2_W-1:0]         dec_d2,
  output logic        [spq_pkg::ENT_W-1:0]        dec_ent
);
  import spq_pkg::*;

  localparam int DW = FRAC_BITS + 2;
  localparam int CW = (X_WIDTH > FRAC_BITS + 3) ? X_WIDTH : FRAC_BITS + 3;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam logic signed [CW-1:0] ONE_C    = CW'(ONE);
  localparam logic signed [CW-1:0] HALF_P   = CW'(HALF);
  localparam logic signed [CW-1:0] HALF_N   = CW'(-HALF);
  localparam logic signed [CW-1:0] TWO_P    = CW'(2 * ONE);
  localparam logic signed [CW-1:0] TWO_N    = CW'(-2 * ONE);
  localparam rom_t                 SIG_ROM  = build_rom(FRAC_BITS);

  logic                   en;
  logic signed [CW-1:0]   xe;
  logic signed [CW-1:0]   d_full;
  logic                   taylor;
  logic [X_WIDTH-1:0]     mag;
  logic [D0_W-1:0]        d0_sel;
  logic [D1_W-1:0]        d1_sel;
  logic signed [D2_W-1:0] d2_sel;

  assign en      = !dec_valid || dec_ready;
  assign x_ready = en;

  always_comb begin
    xe     = CW'(x);
    taylor = (xe >= TWO_N) && (xe < TWO_P);
    mag    = x[X_WIDTH-1] ? X_WIDTH'(-x) : X_WIDTH'(x);
    if (xe < HALF_N) begin
      d_full = xe + ONE_C;
      d0_sel = D0_NEG;
      d1_sel = D1_OUTER;
      d2_sel = D2_NEG;
    end else if (xe < HALF_P) begin
      d_full = xe;
      d0_sel = D0_MID;
      d1_sel = D1_MID;
      d2_sel = D2_MID;
    end else begin
      d_full = xe - ONE_C;
      d0_sel = D0_POS;
      d1_sel = D1_OUTER;
      d2_sel = D2_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (en) begin
      dec_valid <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_taylor <= taylor;
      dec_neg    <= x[X_WIDTH-1];
      dec_d      <= d_full[DW-1:0];
      dec_d0     <= d0_sel;
      dec_d1     <= d1_sel;
      dec_d2     <= d2_sel;
      dec_ent    <= SIG_ROM[mag];
    end
  end

endmodule
`default_nettype wire

// ===== design/spq_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_mul: product stages
// First stage forms the slope term and the square of the offset; second
// stage multiplies the square by the curvature coefficient.
// ----------------------------------------------------------------------------
module spq_mul #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         dec_valid,
  output logic                                         dec_ready,
  input  logic                                         dec_taylor,
  input  logic                                         dec_neg,
  input  logic signed [FRAC_BITS+1:0]                  dec_d,
  input  logic        [spq_pkg::D0_W-1:0]              dec_d0,
  input  logic        [spq_pkg::D1_W-1:0]              dec_d1,
  input  logic signed [spq_pkg::D2_W-1:0]              dec_d2,
  input  logic        [spq_pkg::ENT_W-1:0]             dec_ent,
  output logic                                         prod_valid,
  input  logic                                         prod_ready,
  output logic                                         prod_taylor,
  output logic                                         prod_neg,
  output logic        [spq_pkg::D0_W-1:0]              prod_d0,
  output logic signed [spq_pkg::D1_W+FRAC_BITS+2:0]    prod_p1,
  output logic signed [spq_pkg::D2_W+2*FRAC_BITS+1:0]  prod_p2,
  output logic        [spq_pkg::ENT_W-1:0]             prod_ent
);
  import spq_pkg::*;

  localparam int DW  = FRAC_BITS + 2;
  localparam int DDW = 2 * FRAC_BITS + 1;
  localparam int P1W = D1_W + 1 + DW;
  localparam int P2W = D2_W + DDW + 1;

  logic                   sq_valid;
  logic                   sq_en;
  logic                   prod_en;
  logic signed [2*DW-1:0] sq_full;
  logic                   sq_taylor;
  logic                   sq_neg;
  logic [D0_W-1:0]        sq_d0;
  logic signed [D2_W-1:0] sq_d2;
  logic signed [P1W-1:0]  sq_p1;
  logic [DDW-1:0]         sq_dd;
  logic [ENT_W-1:0]       sq_ent;

  assign prod_en   = !prod_valid || prod_ready;
  assign sq_en     = !sq_valid || prod_en;
  assign dec_ready = sq_en;
  assign sq_full   = dec_d * dec_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (sq_en) begin
        sq_valid <= dec_valid;
      end
      if (prod_en) begin
        prod_valid <= sq_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_en) begin
      sq_taylor <= dec_taylor;
      sq_neg    <= dec_neg;
      sq_d0     <= dec_d0;
      sq_d2     <= dec_d2;
      sq_p1     <= $signed({1'b0, dec_d1}) * dec_d;
      sq_dd     <= sq_full[DDW-1:0];
      sq_ent    <= dec_ent;
    end
    if (prod_en) begin
      prod_taylor <= sq_taylor;
      prod_neg    <= sq_neg;
      prod_d0     <= sq_d0;
      prod_p1     <= sq_p1;
      prod_p2     <= sq_d2 * $signed({1'b0, sq_dd});
      prod_ent    <= sq_ent;
    end
  end

endmodule
`default_nettype wire

// ===== design/spq_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_out: sum, rounding and output register
// Adds the three Taylor terms with the rounding offset, clamps to Q0.16, or
// takes the far-range table entry, mirrored if negative; holds the result.
// ----------------------------------------------------------------------------
module spq_out #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         prod_valid,
  output logic                                         prod_ready,
  input  logic                                         prod_taylor,
  input  logic                                         prod_neg,
  input  logic        [spq_pkg::D0_W-1:0]              prod_d0,
  input  logic signed [spq_pkg::D1_W+FRAC_BITS+2:0]    prod_p1,
  input  logic signed [spq_pkg::D2_W+2*FRAC_BITS+1:0]  prod_p2,
  input  logic        [spq_pkg::ENT_W-1:0]             prod_ent,
  output logic                                         y_valid,
  input  logic                                         y_ready,
  output logic        [spq_pkg::Y_WIDTH-1:0]           y_out
);
  import spq_pkg::*;

  localparam int SH = 2 * FRAC_BITS;
  localparam int SW = D0_W + SH + 3;
  localparam int QW = SW - SH;
  localparam logic [ENT_W-1:0] ENT_ONE = ENT_W'(1 << Y_WIDTH);

  logic                  en;
  logic signed [SW-1:0]  t0;
  logic signed [SW-1:0]  t1;
  logic signed [SW-1:0]  t2;
  logic signed [SW-1:0]  rs;
  logic [QW-1:0]         q;
  logic [Y_WIDTH-1:0]    y_poly;
  logic [ENT_W-1:0]      y_far;
  logic [Y_WIDTH-1:0]    y_rom;

  assign en         = !y_valid || y_ready;
  assign prod_ready = en;

  always_comb begin
    t0 = $signed({3'b000, prod_d0, 1'b1, {(SH - 1){1'b0}}});
    t1 = SW'(prod_p1) <<< FRAC_BITS;
    t2 = SW'(prod_p2);
    rs = t0 + t1 + t2;
    q  = rs[SW-1:SH];
    if (rs[SW-1]) begin
      y_poly = '0;
    end else if (|q[QW-1:Y_WIDTH]) begin
      y_poly = '1;
    end else begin
      y_poly = q[Y_WIDTH-1:0];
    end
    y_far = prod_neg ? (ENT_ONE - prod_ent) : prod_ent;
    y_rom = y_far[ENT_W-1] ? '1 : y_far[Y_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else if (en) begin
      y_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_out <= prod_taylor ? y_poly : y_rom;
    end
  end

endmodule
`default_nettype wire

// ===== design/sigmoid_piecewise_quadratic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigmoid_piecewise_quadratic: pipelined logistic sigmoid
// Signed fixed-point input, unsigned Q0.16 output. Three quadratic Taylor
// segments cover [-2,2); a constant table covers the rest of the range.
//
//   channel  signals                  beat content
//   input    x_valid, x_ready, x_in   one signed sample, FRAC_BITS fraction
//   output   y_valid, y_ready, y_out  sigmoid of that sample, Q0.16
//
// One beat per cycle is accepted and delivered when the output is not held.
// The pipeline has five register stages: input, decode and table read, slope
// and square products, curvature product, sum and output register.
// Reset clears the stage valid bits only; the table is a constant.
// A low y_ready holds each stage that is full, and x_ready drops once the
// whole pipeline is full; no beat is dropped or repeated.
// ----------------------------------------------------------------------------
module sigmoid_piecewise_quadratic #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                x_valid,
  output logic                                x_ready,
  input  logic signed [spq_pkg::X_WIDTH-1:0]  x_in,
  output logic                                y_valid,
  input  logic                                y_ready,
  output logic        [spq_pkg::Y_WIDTH-1:0]  y_out
);
  import spq_pkg::*;

  localparam int DW  = FRAC_BITS + 2;
  localparam int P1W = D1_W + 1 + DW;
  localparam int P2W = D2_W + 2 * FRAC_BITS + 2;

  logic                    in_valid;
  logic                    in_en;
  logic signed [X_WIDTH-1:0] in_x;
  logic                    front_ready;

  logic                    dec_valid;
  logic                    dec_ready;
  logic                    dec_taylor;
  logic                    dec_neg;
  logic signed [DW-1:0]    dec_d;
  logic [D0_W-1:0]         dec_d0;
  logic [D1_W-1:0]         dec_d1;
  logic signed [D2_W-1:0]  dec_d2;
  logic [ENT_W-1:0]        dec_ent;

  logic                    prod_valid;
  logic                    prod_ready;
  logic                    prod_taylor;
  logic                    prod_neg;
  logic [D0_W-1:0]         prod_d0;
  logic signed [P1W-1:0]   prod_p1;
  logic signed [P2W-1:0]   prod_p2;
  logic [ENT_W-1:0]        prod_ent;

  assign in_en   = !in_valid || front_ready;
  assign x_ready = in_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_en) begin
      in_valid <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_en) begin
      in_x <= x_in;
    end
  end

  spq_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .x_valid    (in_valid),
    .x_ready    (front_ready),
    .x          (in_x),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec_taylor (dec_taylor),
    .dec_neg    (dec_neg),
    .dec_d      (dec_d),
    .dec_d0     (dec_d0),
    .dec_d1     (dec_d1),
    .dec_d2     (dec_d2),
    .dec_ent    (dec_ent)
  );

  spq_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk         (clk),
    .rst         (rst),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec_taylor  (dec_taylor),
    .dec_neg     (dec_neg),
    .dec_d       (dec_d),
    .dec_d0      (dec_d0),
    .dec_d1      (dec_d1),
    .dec_d2      (dec_d2),
    .dec_ent     (dec_ent),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .prod_taylor (prod_taylor),
    .prod_neg    (prod_neg),
    .prod_d0     (prod_d0),
    .prod_p1     (prod_p1),
    .prod_p2     (prod_p2),
    .prod_ent    (prod_ent)
  );

  spq_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .prod_taylor (prod_taylor),
    .prod_neg    (prod_neg),
    .prod_d0     (prod_d0),
    .prod_p1     (prod_p1),
    .prod_p2     (prod_p2),
    .prod_ent    (prod_ent),
    .y_valid     (y_valid),
    .y_ready     (y_ready),
    .y_out       (y_out)
  );

endmodule
`default_nettype wire
